FILE: hdl/exptok_pkg.sv
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Shared types, token kind codes and widths for the tokenizer core.
// ----------------------------------------------------------------------------
`default_nettype none

package exptok_pkg;

  localparam int unsigned KwMaxChars = 7;
  localparam int unsigned LineBits   = 20;
  localparam int unsigned ColBits    = 16;
  localparam int unsigned LenBits    = 16;
  localparam int unsigned KindBits   = 6;
  localparam int unsigned KwIdxBits  = $clog2(KwMaxChars + 1);

  // Token kinds, densely numbered: keywords, punctuation, then the rest.
  localparam logic [KindBits-1:0] KVar     = 6'd0;
  localparam logic [KindBits-1:0] KCtr     = 6'd1;
  localparam logic [KindBits-1:0] KCost    = 6'd2;
  localparam logic [KindBits-1:0] KPrec    = 6'd3;
  localparam logic [KindBits-1:0] KAnd     = 6'd4;
  localparam logic [KindBits-1:0] KOr      = 6'd5;
  localparam logic [KindBits-1:0] KNot     = 6'd6;
  localparam logic [KindBits-1:0] KImplies = 6'd7;
  localparam logic [KindBits-1:0] KExp     = 6'd8;
  localparam logic [KindBits-1:0] KLog     = 6'd9;
  localparam logic [KindBits-1:0] KAbs     = 6'd10;
  localparam logic [KindBits-1:0] KSin     = 6'd11;
  localparam logic [KindBits-1:0] KCos     = 6'd12;
  localparam logic [KindBits-1:0] KTan     = 6'd13;
  localparam logic [KindBits-1:0] KAsin    = 6'd14;
  localparam logic [KindBits-1:0] KAcos    = 6'd15;
  localparam logic [KindBits-1:0] KAtan    = 6'd16;
  localparam logic [KindBits-1:0] KAtan2   = 6'd17;
  localparam logic [KindBits-1:0] KSinh    = 6'd18;
  localparam logic [KindBits-1:0] KCosh    = 6'd19;
  localparam logic [KindBits-1:0] KTanh    = 6'd20;
  localparam logic [KindBits-1:0] KMin     = 6'd21;
  localparam logic [KindBits-1:0] KMax     = 6'd22;
  localparam logic [KindBits-1:0] KSqrt    = 6'd23;
  localparam logic [KindBits-1:0] KPow     = 6'd24;
  localparam logic [KindBits-1:0] KLbrack  = 6'd25;
  localparam logic [KindBits-1:0] KRbrack  = 6'd26;
  localparam logic [KindBits-1:0] KLparen  = 6'd27;
  localparam logic [KindBits-1:0] KRparen  = 6'd28;
  localparam logic [KindBits-1:0] KColon   = 6'd29;
  localparam logic [KindBits-1:0] KComma   = 6'd30;
  localparam logic [KindBits-1:0] KSemi    = 6'd31;
  localparam logic [KindBits-1:0] KPlus    = 6'd32;
  localparam logic [KindBits-1:0] KMinus   = 6'd33;
  localparam logic [KindBits-1:0] KStar    = 6'd34;
  localparam logic [KindBits-1:0] KSlash   = 6'd35;
  localparam logic [KindBits-1:0] KCaret   = 6'd36;
  localparam logic [KindBits-1:0] KEq      = 6'd37;
  localparam logic [KindBits-1:0] KLt      = 6'd38;
  localparam logic [KindBits-1:0] KLe      = 6'd39;
  localparam logic [KindBits-1:0] KGt      = 6'd40;
  localparam logic [KindBits-1:0] KGe      = 6'd41;
  localparam logic [KindBits-1:0] KNumber  = 6'd42;
  localparam logic [KindBits-1:0] KIdent   = 6'd43;
  localparam logic [KindBits-1:0] KEnd     = 6'd44;
  localparam logic [KindBits-1:0] KError   = 6'd45;

  typedef enum logic [11:0] {
    M_IDLE     = 12'b000000000001,
    M_COMMENT  = 12'b000000000010,
    M_IDENT    = 12'b000000000100,
    M_INT      = 12'b000000001000,
    M_FRAC     = 12'b000000010000,
    M_EXPSTART = 12'b000000100000,
    M_EXPDIG   = 12'b000001000000,
    M_EQ       = 12'b000010000000,
    M_LT       = 12'b000100000000,
    M_GT       = 12'b001000000000,
    M_STUCK    = 12'b010000000000,
    M_DONE     = 12'b100000000000
  } mode_e;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [LineBits-1:0] line;
    logic [ColBits-1:0]  col;
    logic [LenBits-1:0]  len;
  } token_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [KindBits-1:0] token_kind;
    logic [LineBits-1:0] origin_line;
    logic [ColBits-1:0]  start_column;
    logic [LenBits-1:0]  token_length;
    logic                last_of_run;
  } out_item_t;

  typedef logic [KwMaxChars-1:0][7:0] kwbuf_t;

  // Pads a keyword spelling into buffer layout (character 0 in the low byte).
  function automatic kwbuf_t kw(input logic [8*KwMaxChars-1:0] s, input int unsigned n);
    kwbuf_t b;
    b = '0;
    for (int i = 0; i < KwMaxChars; i++) begin
      if (i < n) b[i] = s[8*(n-1-i) +: 8];
    end
    return b;
  endfunction

  // Keyword match; returns the identifier kind when nothing matches.
  function automatic logic [KindBits-1:0] kw_lookup(input kwbuf_t b,
                                                   input logic [LenBits-1:0] n,
                                                   input logic ovf);
    logic [KindBits-1:0] k;
    k = KIdent;
    if (!ovf && n <= LenBits'(KwMaxChars)) begin
      case (n)
        16'd2: if (b == kw("or", 2)) k = KOr;
        16'd3: begin
          if (b == kw("var", 3)) k = KVar;
          if (b == kw("ctr", 3)) k = KCtr;
          if (b == kw("and", 3)) k = KAnd;
          if (b == kw("not", 3)) k = KNot;
          if (b == kw("exp", 3)) k = KExp;
          if (b == kw("log", 3)) k = KLog;
          if (b == kw("abs", 3)) k = KAbs;
          if (b == kw("sin", 3)) k = KSin;
          if (b == kw("cos", 3)) k = KCos;
          if (b == kw("tan", 3)) k = KTan;
          if (b == kw("min", 3)) k = KMin;
          if (b == kw("max", 3)) k = KMax;
          if (b == kw("pow", 3)) k = KPow;
        end
        16'd4: begin
          if (b == kw("cost", 4)) k = KCost;
          if (b == kw("prec", 4)) k = KPrec;
          if (b == kw("asin", 4)) k = KAsin;
          if (b == kw("acos", 4)) k = KAcos;
          if (b == kw("atan", 4)) k = KAtan;
          if (b == kw("sinh", 4)) k = KSinh;
          if (b == kw("cosh", 4)) k = KCosh;
          if (b == kw("tanh", 4)) k = KTanh;
          if (b == kw("sqrt", 4)) k = KSqrt;
        end
        16'd5: if (b == kw("atan2", 5)) k = KAtan2;
        16'd6: begin
          if (b == kw("arcsin", 6)) k = KAsin;
          if (b == kw("arccos", 6)) k = KAcos;
          if (b == kw("arctan", 6)) k = KAtan;
        end
        16'd7: begin
          if (b == kw("implies", 7)) k = KImplies;
          if (b == kw("arctan2", 7)) k = KAtan2;
        end
        default: k = KIdent;
      endcase
    end
    return k;
  endfunction

  // Single-character punctuation; valid flag in the top bit.
  function automatic logic [KindBits:0] punct(input logic [7:0] c);
    logic [KindBits:0] r;
    case (c)
      8'h5B: r = {1'b1, KLbrack};
      8'h5D: r = {1'b1, KRbrack};
      8'h28: r = {1'b1, KLparen};
      8'h29: r = {1'b1, KRparen};
      8'h3A: r = {1'b1, KColon};
      8'h2C: r = {1'b1, KComma};
      8'h3B: r = {1'b1, KSemi};
      8'h2B: r = {1'b1, KPlus};
      8'h2D: r = {1'b1, KMinus};
      8'h2A: r = {1'b1, KStar};
      8'h2F: r = {1'b1, KSlash};
      8'h5E: r = {1'b1, KCaret};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/exptok_stream_if.sv
// ----------------------------------------------------------------------------
// Tokenizer stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface exptok_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/expression_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Expression tokenizer core
// Scans one character per request and emits up to three tokens per request.
// ----------------------------------------------------------------------------
// Tokens are registered; a request's first token is offered in the cycle after
// acceptance. Throughput: one request per cycle if it yields at most one token
// and the receiver is ready; otherwise the next request is taken in the cycle
// its last token leaves; one token leaves per cycle when the output is ready.
// Reset: asynchronous, clears scan state to line 1, column 1, idle.
`default_nettype none

module expression_tokenizer_core
  import exptok_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  exptok_stream_if.sink   in_i,
  exptok_stream_if.source out_o
);

  localparam logic [LineBits-1:0] LineMax = '1;
  localparam logic [ColBits-1:0]  ColMax  = '1;
  localparam logic [LenBits-1:0]  LenMax  = '1;

  mode_e               mode_q, mode_d;
  logic [LineBits-1:0] line_q, line_d, tline_q, tline_d;
  logic [ColBits-1:0]  col_q, col_d, tcol_q, tcol_d;
  logic [LenBits-1:0]  plen_q, plen_d;
  kwbuf_t              kbuf_q, kbuf_d;
  logic                kovf_q, kovf_d;

  // Result buffer: up to three tokens from one request, drained in order.
  token_t    [2:0] buf_q;
  logic      [1:0] cnt_q, rd_q;
  token_t    [2:0] em;
  logic      [1:0] n;
  logic            accept;

  in_item_t   it;
  logic [7:0] c;
  assign it = in_i.data;
  assign c  = it.char_code;

  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == rd_q + 2'd1 && out_o.ready);
  assign accept = in_i.valid && in_i.ready;

  // Character classes.
  logic is_dig, is_alp, is_sp, is_e;
  logic [KindBits:0] pk;
  always_comb begin
    is_dig = c inside {[8'h30:8'h39]};
    is_alp = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_sp  = c == 8'h20 || c inside {[8'd9:8'd13]};
    is_e   = c == 8'h65 || c == 8'h45;
    pk     = punct(c);
  end

  // Per-request scanning step.
  always_comb begin
    logic flushit, adv, grow_it;
    logic [KindBits-1:0] fk;
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    plen_d  = plen_q;
    kbuf_d  = kbuf_q;
    kovf_d  = kovf_q;
    em      = '0;
    n       = 2'd0;
    flushit = 1'b0;
    adv     = 1'b0;
    grow_it = 1'b0;
    fk      = KIdent;

    if (mode_q == M_DONE) begin
      em[0] = '{KEnd, line_q, col_q, '0};
      n = 2'd1;
    end else if (mode_q != M_STUCK) begin
      if (it.char_present) begin
        case (mode_q)
          M_COMMENT: begin
            if (c == 8'h0A) mode_d = M_IDLE;
            adv = 1'b1;
          end
          M_IDENT: begin
            if (is_alp || is_dig || c == 8'h5F || c == 8'h2E) begin
              if (plen_q < LenBits'(KwMaxChars)) kbuf_d[plen_q[KwIdxBits-1:0]] = c;
              else kovf_d = 1'b1;
              grow_it = 1'b1;
            end else flushit = 1'b1;
          end
          M_INT: begin
            if (is_dig) grow_it = 1'b1;
            else if (c == 8'h2E) begin mode_d = M_FRAC; grow_it = 1'b1; end
            else if (is_e) begin mode_d = M_EXPSTART; grow_it = 1'b1; end
            else flushit = 1'b1;
          end
          M_FRAC: begin
            if (is_dig) grow_it = 1'b1;
            else if (is_e) begin mode_d = M_EXPSTART; grow_it = 1'b1; end
            else flushit = 1'b1;
          end
          M_EXPSTART: begin
            if (is_dig || c == 8'h2B || c == 8'h2D) begin
              mode_d = M_EXPDIG; grow_it = 1'b1;
            end else flushit = 1'b1;
          end
          M_EXPDIG: begin
            if (is_dig) grow_it = 1'b1;
            else flushit = 1'b1;
          end
          M_EQ, M_LT, M_GT: begin
            if ((mode_q == M_EQ && c == 8'h3E) || (mode_q != M_EQ && c == 8'h3D)) begin
              em[0] = '{(mode_q == M_EQ) ? KImplies : ((mode_q == M_LT) ? KLe : KGe),
                        tline_q, tcol_q, LenBits'(2)};
              n = 2'd1;
              mode_d = M_IDLE;
              adv = 1'b1;
            end else flushit = 1'b1;
          end
          default: flushit = 1'b1;
        endcase

        if (grow_it) begin
          if (plen_q != LenMax) plen_d = plen_q + 1'b1;
          adv = 1'b1;
        end

        if (flushit) begin
          // Close the pending token, then treat the character from idle.
          case (mode_q)
            M_IDENT: begin fk = kw_lookup(kbuf_q, plen_q, kovf_q); n = 2'd1; end
            M_INT, M_FRAC, M_EXPSTART, M_EXPDIG: begin fk = KNumber; n = 2'd1; end
            M_EQ: begin fk = KEq; n = 2'd1; end
            M_LT: begin fk = KLt; n = 2'd1; end
            M_GT: begin fk = KGt; n = 2'd1; end
            default: n = 2'd0;
          endcase
          em[0] = '{fk, tline_q, tcol_q, plen_q};
          mode_d = M_IDLE;
          adv = 1'b1;
          if (is_sp) begin
          end else if (c == 8'h23) begin
            mode_d = M_COMMENT;
          end else if (pk[KindBits]) begin
            em[n] = '{pk[KindBits-1:0], line_q, col_q, LenBits'(1)};
            n = n + 2'd1;
          end else if (c == 8'h3D || c == 8'h3C || c == 8'h3E) begin
            mode_d = (c == 8'h3D) ? M_EQ : ((c == 8'h3C) ? M_LT : M_GT);
            tline_d = line_q; tcol_d = col_q; plen_d = LenBits'(1);
          end else if (is_dig) begin
            mode_d = M_INT;
            tline_d = line_q; tcol_d = col_q; plen_d = LenBits'(1);
          end else if (is_alp) begin
            mode_d = M_IDENT;
            tline_d = line_q; tcol_d = col_q; plen_d = LenBits'(1);
            kbuf_d = '0; kbuf_d[0] = c; kovf_d = 1'b0;
          end else begin
            em[n] = '{KError, line_q, col_q, LenBits'(1)};
            n = n + 2'd1;
            mode_d = M_STUCK;
          end
        end

        if (adv) begin
          if (c == 8'h0A) begin
            if (line_q != LineMax) line_d = line_q + 1'b1;
            col_d = ColBits'(1);
          end else if (col_q != ColMax) col_d = col_q + 1'b1;
        end
      end

      if (it.end_of_input && mode_d != M_STUCK) begin
        case (mode_d)
          M_IDENT: begin
            em[n] = '{kw_lookup(kbuf_d, plen_d, kovf_d), tline_d, tcol_d, plen_d};
            n = n + 2'd1;
          end
          M_INT, M_FRAC, M_EXPSTART, M_EXPDIG: begin
            em[n] = '{KNumber, tline_d, tcol_d, plen_d}; n = n + 2'd1;
          end
          M_EQ: begin em[n] = '{KEq, tline_d, tcol_d, plen_d}; n = n + 2'd1; end
          M_LT: begin em[n] = '{KLt, tline_d, tcol_d, plen_d}; n = n + 2'd1; end
          M_GT: begin em[n] = '{KGt, tline_d, tcol_d, plen_d}; n = n + 2'd1; end
          default: n = n;
        endcase
        em[n] = '{KEnd, line_d, col_d, '0};
        n = n + 2'd1;
        mode_d = M_DONE;
      end
    end
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= LineBits'(1);
      col_q   <= ColBits'(1);
      tline_q <= LineBits'(1);
      tcol_q  <= ColBits'(1);
      plen_q  <= '0;
      kbuf_q  <= '0;
      kovf_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      plen_q  <= plen_d;
      kbuf_q  <= kbuf_d;
      kovf_q  <= kovf_d;
    end
  end

  // Result buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (accept) begin
      cnt_q <= n;
      rd_q  <= 2'd0;
    end else if (out_o.valid && out_o.ready) begin
      if (rd_q + 2'd1 == cnt_q) begin
        cnt_q <= 2'd0;
        rd_q  <= 2'd0;
      end else rd_q <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) buf_q <= em;
  end

  // Output side.
  token_t    cur;
  out_item_t oi;
  always_comb begin
    cur = buf_q[0];
    case (rd_q)
      2'd0: cur = buf_q[0];
      2'd1: cur = buf_q[1];
      2'd2: cur = buf_q[2];
      default: cur = buf_q[0];
    endcase
    oi = '{cur.kind, cur.line, cur.col, cur.len, (rd_q + 2'd1 == cnt_q)};
  end

  assign out_o.valid = cnt_q != 2'd0;
  assign out_o.data  = oi;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Tokenizer core testbench
// Streams character requests into the core and predicts every token that it
// must emit, checking each token field by field, in order, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import exptok_pkg::*;

  localparam int unsigned LineMax = (1 << LineBits) - 1;
  localparam int unsigned ColMax  = (1 << ColBits) - 1;
  localparam int unsigned LenMax  = 65535;
  localparam byte unsigned ChNl   = 8'd10;

  localparam string KwSpell [29] = '{
    "var", "ctr", "cost", "prec", "and", "or", "not", "implies", "exp", "log",
    "abs", "sin", "cos", "tan", "asin", "arcsin", "acos", "arccos", "atan",
    "arctan", "atan2", "arctan2", "sinh", "cosh", "tanh", "min", "max", "sqrt",
    "pow"};
  localparam logic [KindBits-1:0] KwKind [29] = '{
    KVar, KCtr, KCost, KPrec, KAnd, KOr, KNot, KImplies, KExp,
    KLog, KAbs, KSin, KCos, KTan, KAsin, KAsin, KAcos, KAcos,
    KAtan, KAtan, KAtan2, KAtan2, KSinh, KCosh, KTanh, KMin,
    KMax, KSqrt, KPow};

  logic clk_i;
  logic rst_ni;

  exptok_stream_if #(.payload_t(in_item_t))  in_if ();
  exptok_stream_if #(.payload_t(out_item_t)) out_if ();

  expression_tokenizer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // Scanner state mirrored by the predictor.
  mode_e        scan_st;
  int unsigned  cur_line, cur_col, tok_line, tok_col, tok_len;
  byte unsigned kw_buf [KwMaxChars];
  bit           kw_ovf;
  int           run_tokens;

  out_item_t    expected_tokens [$];
  int           error_count;
  bit           quiet;
  bit           hold_req;

  // Clock and the global time limit.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit is_digit(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(byte unsigned c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(byte unsigned c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int punct_kind(byte unsigned c);
    case (c)
      "[": return int'(KLbrack);
      "]": return int'(KRbrack);
      "(": return int'(KLparen);
      ")": return int'(KRparen);
      ":": return int'(KColon);
      ",": return int'(KComma);
      ";": return int'(KSemi);
      "+": return int'(KPlus);
      "-": return int'(KMinus);
      "*": return int'(KStar);
      "/": return int'(KSlash);
      "^": return int'(KCaret);
      default: return -1;
    endcase
  endfunction

  function automatic void push_token(logic [5:0] kind, int unsigned l, int unsigned c,
                                     int unsigned len);
    out_item_t t;
    t.token_kind   = kind;
    t.origin_line  = l[LineBits-1:0];
    t.start_column = c[ColBits-1:0];
    t.token_length = len[LenBits-1:0];
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
    run_tokens++;
  endfunction

  // Line and column bookkeeping, both saturating.
  function automatic void step_pos(byte unsigned c);
    if (c == ChNl) begin
      if (cur_line < LineMax) cur_line++;
      cur_col = 1;
    end else if (cur_col < ColMax) begin
      cur_col++;
    end
  endfunction

  function automatic void start_tok(mode_e m);
    scan_st  = m;
    tok_line = cur_line;
    tok_col  = cur_col;
    tok_len  = 1;
  endfunction

  function automatic void extend_tok(byte unsigned c);
    if (tok_len < LenMax) tok_len++;
    step_pos(c);
  endfunction

  function automatic logic [5:0] keyword_kind();
    bit hit;
    if (kw_ovf || tok_len > KwMaxChars) return KIdent;
    for (int i = 0; i < 29; i++) begin
      if (KwSpell[i].len() == tok_len) begin
        hit = 1'b1;
        for (int j = 0; j < KwSpell[i].len(); j++)
          if (KwSpell[i][j] != kw_buf[j]) hit = 1'b0;
        if (hit) return KwKind[i];
      end
    end
    return KIdent;
  endfunction

  // Emits the pending token, if any, and in that case returns to idle.
  function automatic void close_tok();
    logic [5:0] kind;
    case (scan_st)
      M_IDENT: kind = keyword_kind();
      M_INT, M_FRAC, M_EXPSTART, M_EXPDIG: kind = KNumber;
      M_EQ: kind = KEq;
      M_LT: kind = KLt;
      M_GT: kind = KGt;
      default: return;
    endcase
    push_token(kind, tok_line, tok_col, tok_len);
    scan_st = M_IDLE;
  endfunction

  function automatic void start_char(byte unsigned c);
    int pk;
    pk = punct_kind(c);
    scan_st = M_IDLE;
    if (is_space(c)) begin
      step_pos(c);
    end else if (c == "#") begin
      scan_st = M_COMMENT;
      step_pos(c);
    end else if (pk >= 0) begin
      push_token(pk[5:0], cur_line, cur_col, 1);
      step_pos(c);
    end else if (c == "=" || c == "<" || c == ">") begin
      start_tok(c == "=" ? M_EQ : (c == "<" ? M_LT : M_GT));
      step_pos(c);
    end else if (is_digit(c)) begin
      start_tok(M_INT);
      step_pos(c);
    end else if (is_alpha(c)) begin
      start_tok(M_IDENT);
      foreach (kw_buf[i]) kw_buf[i] = 8'd0;
      kw_buf[0] = c;
      kw_ovf = 1'b0;
      step_pos(c);
    end else begin
      push_token(KError, cur_line, cur_col, 1);
      step_pos(c);
      scan_st = M_STUCK;
    end
  endfunction

  function automatic void scan_char(byte unsigned c);
    byte unsigned want;
    case (scan_st)
      M_STUCK: return;
      M_COMMENT: begin
        if (c == ChNl) scan_st = M_IDLE;
        step_pos(c);
        return;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_" || c == ".") begin
          if (tok_len < KwMaxChars) kw_buf[tok_len] = c;
          else kw_ovf = 1'b1;
          extend_tok(c);
          return;
        end
      end
      M_INT, M_FRAC: begin
        if (is_digit(c)) begin
          extend_tok(c);
          return;
        end
        if (c == "." && scan_st == M_INT) begin
          scan_st = M_FRAC;
          extend_tok(c);
          return;
        end
        if (c == "e" || c == "E") begin
          scan_st = M_EXPSTART;
          extend_tok(c);
          return;
        end
      end
      M_EXPSTART: begin
        if (is_digit(c) || c == "+" || c == "-") begin
          scan_st = M_EXPDIG;
          extend_tok(c);
          return;
        end
      end
      M_EXPDIG: begin
        if (is_digit(c)) begin
          extend_tok(c);
          return;
        end
      end
      M_EQ, M_LT, M_GT: begin
        want = (scan_st == M_EQ) ? ">" : "=";
        if (c == want) begin
          push_token(scan_st == M_EQ ? KImplies : (scan_st == M_LT ? KLe : KGe),
                     tok_line, tok_col, 2);
          scan_st = M_IDLE;
          step_pos(c);
          return;
        end
      end
      default: ;
    endcase
    close_tok();
    start_char(c);
  endfunction

  // Works out the tokens that one accepted request must yield.
  function automatic void predict_tokens(in_item_t it);
    run_tokens = 0;
    if (scan_st == M_DONE) begin
      push_token(KEnd, cur_line, cur_col, 0);
    end else if (scan_st != M_STUCK) begin
      if (it.char_present) scan_char(it.char_code);
      if (it.end_of_input && scan_st != M_STUCK) begin
        close_tok();
        push_token(KEnd, cur_line, cur_col, 0);
        scan_st = M_DONE;
      end
    end
    if (run_tokens > 0) expected_tokens[expected_tokens.size()-1].last_of_run = 1'b1;
  endfunction

  // Offers one request, with an occasional idle burst before it.
  task automatic send_char(byte unsigned c, bit present, bit ending);
    in_item_t it;
    bit taken;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    it.char_code    = c;
    it.char_present = present;
    it.end_of_input = ending;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    predict_tokens(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (!quiet && $urandom_range(0, 19) == 0) send_char(8'($urandom), 1'b0, 1'b0);
      send_char(s[i], 1'b1, 1'b0);
    end
  endtask

  function automatic string chr(byte unsigned b);
    string s;
    s = " ";
    s.putc(0, b);
    return s;
  endfunction

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, chr(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  // One random lexeme, well formed except for deliberately broken pairs and exponents.
  function automatic string random_lexeme();
    string s, pool;
    case ($urandom_range(0, 11))
      0, 1: begin
        s = KwSpell[$urandom_range(0, 28)];
        if ($urandom_range(0, 3) == 0) s = {s, chr("_")};
      end
      2: begin
        pool = "abcXYZ09_.qE";
        s = chr(is_alpha(8'($urandom)) ? "k" : "Q");
        repeat ($urandom_range(0, 10)) s = {s, chr(pool[$urandom_range(0, 11)])};
      end
      3, 4: begin
        s = digits($urandom_range(1, 4));
        case ($urandom_range(0, 5))
          0: s = {s, ".", digits($urandom_range(0, 3))};
          1: s = {s, "e", digits($urandom_range(1, 2))};
          2: s = {s, ".", digits(1), "E-", digits(2)};
          3: s = {s, chr($urandom_range(0, 1) ? "e" : "E"), chr("+")};
          4: s = {s, "e"};
          default: ;
        endcase
      end
      5, 6: begin
        pool = "[]():,;+-*/^";
        s = chr(pool[$urandom_range(0, 11)]);
      end
      7: begin
        case ($urandom_range(0, 6))
          0: s = "<=";
          1: s = ">=";
          2: s = "=>";
          3: s = "=";
          4: s = "<";
          5: s = ">";
          default: s = "==";
        endcase
      end
      8, 9: begin
        pool = " \t\n\v\f\r";
        s = chr(pool[$urandom_range(0, 5)]);
      end
      10: begin
        // Comment text holds bytes from 11 to 255, so never a newline or zero.
        s = "#";
        repeat ($urandom_range(0, 5)) s = {s, chr(8'($urandom_range(11, 255)))};
        s = {s, "\n"};
      end
      default: s = " ";
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // A directed mix of token shapes, with a request that carries no character.
  task automatic test_directed();
    send_text("arctan2 a_.Z9 0.1e+9<=]#\xff\n");
    send_char(8'd0, 1'b0, 1'b0);
    send_text("5.=>x>=");
  endtask

  task automatic test_random_stream(int n);
    int sent;
    string s;
    sent = 0;
    while (sent < n) begin
      s = random_lexeme();
      send_text(s);
      sent += s.len();
      if ($urandom_range(0, 2) == 0) begin
        send_text(" ");
        sent++;
      end
    end
  endtask

  // The receiver holds off while requests keep coming, so the core stalls.
  task automatic test_output_holdoff();
    hold_req = 1'b1;
    test_random_stream(40);
  endtask

  task automatic test_sender_pause();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    @(posedge clk_i);
    send_text("max(1,2);");
  endtask

  // One identifier longer than any keyword, so the spelling buffer overflows.
  task automatic test_long_token();
    send_char("a", 1'b1, 1'b0);
    repeat (12) send_char("b", 1'b1, 1'b0);
    send_text("\ncos\n");
  endtask

  // End of input on a request that yields three tokens, then requests after the end.
  task automatic test_end_of_input();
    send_char("<", 1'b1, 1'b0);
    send_char("(", 1'b1, 1'b1);
    send_char(8'hff, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b1);
    send_char(8'h00, 1'b0, 1'b0);
  endtask

  // Receiver ready, with random stalls and one long hold-off on request.
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (!quiet && stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  // Token checker: a token is taken at the next rising edge.
  always @(negedge clk_i) begin
    out_item_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_tokens.size() == 0) begin
        $display("%0t: token with none expected, actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind) begin
          $display("%0t: token_kind expected %0d actual %0d", $time,
                   want.token_kind, got.token_kind);
          error_count++;
        end
        if (got.origin_line !== want.origin_line) begin
          $display("%0t: origin_line expected %0d actual %0d", $time,
                   want.origin_line, got.origin_line);
          error_count++;
        end
        if (got.start_column !== want.start_column) begin
          $display("%0t: start_column expected %0d actual %0d", $time,
                   want.start_column, got.start_column);
          error_count++;
        end
        if (got.token_length !== want.token_length) begin
          $display("%0t: token_length expected %0d actual %0d", $time,
                   want.token_length, got.token_length);
          error_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time,
                   want.last_of_run, got.last_of_run);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    scan_st     = M_IDLE;
    cur_line    = 1;
    cur_col     = 1;
    tok_line    = 1;
    tok_col     = 1;
    tok_len     = 0;
    kw_ovf      = 1'b0;
    foreach (kw_buf[i]) kw_buf[i] = 8'd0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_stream(200);
    test_output_holdoff();
    test_sender_pause();
    test_random_stream(180);
    quiet = 1'b1;
    test_random_stream(30);
    test_long_token();
    test_end_of_input();

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/exptok_pkg.sv
hdl/exptok_stream_if.sv
hdl/expression_tokenizer_core.sv
dv/tb_top.sv
